FILE: rtl/lhe_pkg.sv
// lhe_pkg: shared types, constants and helper functions of the latency histogram engine
// no dependencies; used by lhe_div, latency_histogram_engine and the verification packages
package lhe_pkg;

  localparam int DEF_NUM_CHANNELS = 8;
  localparam int NUM_BUCKETS      = 12;

  localparam int CNT_W = 32;
  localparam int SUM_W = 64;
  localparam int CH_W  = 3;
  localparam int PCT_W = 7;
  localparam int BKT_W = 4;

  localparam logic [BKT_W-1:0] LAST_BKT  = BKT_W'(NUM_BUCKETS - 1);
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;
  localparam logic [PCT_W-1:0] PCT_MAX   = 7'd100;
  localparam int               PCT_SCALE = 100;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_PCT     = 2'd1,
    OP_AVG     = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef struct packed {
    logic             start;
    logic [SUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [CNT_W-1:0] quotient;
  } div_rsp_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == CNT_MAX) ? v : v + CNT_W'(1);
  endfunction

  // upper bound of each bucket, overflow bucket reports 10 s
  function automatic logic [CNT_W-1:0] bucket_bound(input logic [BKT_W-1:0] idx);
    logic [CNT_W-1:0] b;
    case (idx)
      4'd0:    b = 32'd100;
      4'd1:    b = 32'd250;
      4'd2:    b = 32'd500;
      4'd3:    b = 32'd1000;
      4'd4:    b = 32'd2500;
      4'd5:    b = 32'd5000;
      4'd6:    b = 32'd10000;
      4'd7:    b = 32'd25000;
      4'd8:    b = 32'd50000;
      4'd9:    b = 32'd100000;
      4'd10:   b = 32'd1000000;
      default: b = 32'd10000000;
    endcase
    return b;
  endfunction

  // first bucket whose bound is not exceeded
  function automatic logic [BKT_W-1:0] bucket_of(input logic [CNT_W-1:0] lat);
    logic [BKT_W-1:0] b;
    b = LAST_BKT;
    for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
      if (lat <= bucket_bound(BKT_W'(i))) b = BKT_W'(i);
    end
    return b;
  endfunction

endpackage

FILE: rtl/lhe_div.sv
// lhe_div: radix-2 restoring divider for the average query, one quotient bit per cycle
// depends on lhe_pkg; the caller guarantees the upper dividend half is below the divisor
module lhe_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lhe_pkg::div_req_t req_i,
  output lhe_pkg::div_rsp_t rsp_o
);
  import lhe_pkg::*;

  localparam int STEP_W = $clog2(CNT_W);

  logic              busy_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  quo_q;
  logic [CNT_W-1:0]  dsr_q;
  logic [CNT_W+1:0]  trial;

  assign trial = {1'b0, rem_q, quo_q[CNT_W-1]} - {2'b00, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= '1;
      end else if (busy_q) begin
        step_q <= step_q - STEP_W'(1);
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // low dividend bits shift out at the top while quotient bits shift in at the bottom
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend[SUM_W-1:CNT_W];
      quo_q <= req_i.dividend[CNT_W-1:0];
      dsr_q <= req_i.divisor;
    end else if (busy_q) begin
      if (!trial[CNT_W+1]) begin
        rem_q <= trial[CNT_W-1:0];
        quo_q <= {quo_q[CNT_W-2:0], 1'b1};
      end else begin
        rem_q <= {rem_q[CNT_W-2:0], quo_q[CNT_W-1]};
        quo_q <= {quo_q[CNT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

FILE: rtl/latency_histogram_engine.sv
// latency_histogram_engine: per-channel latency histograms with percentile, average
// and bucket read queries; depends on lhe_pkg and lhe_div
//
// Observe transfers are taken every cycle while no query is in flight: each one reads its
// bucket count and its channel's total and sum from two single-port-read synchronous
// memories and in the next cycle writes them back incremented, so a new one enters every
// cycle while the last is written back. Back-to-back hits on the same entry are served by
// forwarding the last write. Queries run one at a time and hold off further input transfers
// while they work: a bucket count read returns the stored count, an average runs the serial
// divider unless the histogram is empty or the quotient saturates, and a percentile reads
// one bucket memory entry per bucket walked. The result sits in an output register, so a
// waiting result does not stop observes. All stores read as zero after reset: every memory
// entry has a valid bit cleared by reset, so no clearing pass is needed.
module latency_histogram_engine #(
  parameter int NUM_CHANNELS = lhe_pkg::DEF_NUM_CHANNELS
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // item channel
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lhe_pkg::op_e               op_i,
  input  logic [lhe_pkg::CH_W-1:0]   channel_i,
  input  logic [lhe_pkg::CNT_W-1:0]  latency_us_i,
  input  logic [lhe_pkg::PCT_W-1:0]  percentile_i,
  input  logic [lhe_pkg::BKT_W-1:0]  bucket_index_i,
  // result channel
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [lhe_pkg::CNT_W-1:0]  value_o,
  output logic [lhe_pkg::CNT_W-1:0]  sample_total_o
);
  import lhe_pkg::*;

  localparam int NUM_ENTRIES = NUM_CHANNELS * NUM_BUCKETS;
  localparam int BA_W        = $clog2(NUM_ENTRIES);
  localparam int CA_W        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int TGT_W       = CNT_W + PCT_W;
  // 100 * sum of all buckets, with room for twelve saturated counters
  localparam int ACC_W       = CNT_W + 11;

  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] total;
  } chan_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_WALK = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  // ---------------------------------------------------------------------------------------
  // input transfer and address generation
  // ---------------------------------------------------------------------------------------
  logic             in_accept;
  logic             in_range;
  logic             in_bidx_ok;
  logic [CA_W-1:0]  in_ch;
  logic [BKT_W-1:0] in_bkt;
  logic [BA_W-1:0]  in_baddr;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_range   = (32'(channel_i) < NUM_CHANNELS);
  assign in_bidx_ok = (bucket_index_i <= LAST_BKT);
  assign in_ch      = CA_W'(channel_i);
  // observe addresses the bucket it falls in, a bucket read the requested one
  assign in_bkt     = (op_i == OP_OBSERVE) ? bucket_of(latency_us_i) :
                      (in_bidx_ok ? bucket_index_i : '0);
  assign in_baddr   = BA_W'(32'(in_ch) * NUM_BUCKETS + 32'(in_bkt));

  // second stage: memory read data is available here
  logic             s1_valid_q;
  op_e              s1_op_q;
  logic [CA_W-1:0]  s1_ch_q;
  logic             s1_in_range_q;
  logic             s1_bidx_ok_q;
  logic [CNT_W-1:0] s1_lat_q;
  logic [PCT_W-1:0] s1_pct_q;
  logic             s1_query;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_op_q       <= op_i;
      s1_ch_q       <= in_ch;
      s1_in_range_q <= in_range;
      s1_bidx_ok_q  <= in_bidx_ok;
      s1_lat_q      <= latency_us_i;
      s1_pct_q      <= percentile_i;
    end
  end

  assign s1_query = s1_valid_q && (s1_op_q != OP_OBSERVE);

  state_e state_q, state_d;

  // queries hold the input side until their result is in the output register
  assign in_stall_o = s1_query || (state_q != ST_IDLE);

  // ---------------------------------------------------------------------------------------
  // bucket count memory
  // ---------------------------------------------------------------------------------------
  logic [BKT_W-1:0]       widx_q, widx_d;
  logic [BA_W-1:0]        ch_base;
  logic [BA_W-1:0]        walk_raddr;
  logic [BA_W-1:0]        bmem_raddr;
  logic                   bmem_we;
  logic [CNT_W-1:0]       bmem_wdata;
  logic [CNT_W-1:0]       bmem [NUM_ENTRIES];
  logic [CNT_W-1:0]       brdata_q;
  logic [NUM_ENTRIES-1:0] bvld_q;
  logic                   brvld_q;
  logic [BA_W-1:0]        braddr_q;
  logic                   bwr_vld_q;
  logic [BA_W-1:0]        bwr_addr_q;
  logic [CNT_W-1:0]       bwr_data_q;
  logic [CNT_W-1:0]       bcnt_eff;

  assign ch_base    = BA_W'(32'(s1_ch_q) * NUM_BUCKETS);
  // the walk fetches one bucket ahead of the one being summed
  assign walk_raddr = ((state_q == ST_WALK) && (widx_q != LAST_BKT)) ?
                      ch_base + BA_W'(widx_q + BKT_W'(1)) : ch_base;
  assign bmem_raddr = in_stall_o ? walk_raddr : in_baddr;

  always_ff @(posedge clk_i) begin
    if (bmem_we) begin
      bmem[braddr_q] <= bmem_wdata;
    end
    brdata_q <= bmem[bmem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bvld_q     <= '0;
      brvld_q    <= 1'b0;
      braddr_q   <= '0;
      bwr_vld_q  <= 1'b0;
      bwr_addr_q <= '0;
      bwr_data_q <= '0;
    end else begin
      brvld_q    <= bvld_q[bmem_raddr];
      braddr_q   <= bmem_raddr;
      bwr_vld_q  <= bmem_we;
      bwr_addr_q <= braddr_q;
      bwr_data_q <= bmem_wdata;
      if (bmem_we) begin
        bvld_q[braddr_q] <= 1'b1;
      end
    end
  end

  // a write in the read's own cycle is not seen by the array read, so forward it
  assign bcnt_eff = (bwr_vld_q && (bwr_addr_q == braddr_q)) ? bwr_data_q :
                    (brvld_q ? brdata_q : '0);

  // ---------------------------------------------------------------------------------------
  // channel memory: total and sum side by side
  // ---------------------------------------------------------------------------------------
  logic                    cmem_we;
  chan_entry_t             cmem_wdata;
  chan_entry_t             cmem [NUM_CHANNELS];
  chan_entry_t             crdata_q;
  logic [NUM_CHANNELS-1:0] cvld_q;
  logic                    crvld_q;
  logic [CA_W-1:0]         craddr_q;
  logic                    cwr_vld_q;
  logic [CA_W-1:0]         cwr_addr_q;
  chan_entry_t             cwr_data_q;
  chan_entry_t             ceff;

  always_ff @(posedge clk_i) begin
    if (cmem_we) begin
      cmem[craddr_q] <= cmem_wdata;
    end
    crdata_q <= cmem[in_ch];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvld_q     <= '0;
      crvld_q    <= 1'b0;
      craddr_q   <= '0;
      cwr_vld_q  <= 1'b0;
      cwr_addr_q <= '0;
      cwr_data_q <= '0;
    end else begin
      crvld_q    <= cvld_q[in_ch];
      craddr_q   <= in_ch;
      cwr_vld_q  <= cmem_we;
      cwr_addr_q <= craddr_q;
      cwr_data_q <= cmem_wdata;
      if (cmem_we) begin
        cvld_q[craddr_q] <= 1'b1;
      end
    end
  end

  assign ceff = (cwr_vld_q && (cwr_addr_q == craddr_q)) ? cwr_data_q :
                (crvld_q ? crdata_q : '0);

  // observe write-back: counters saturate, the sum wraps
  assign bmem_we          = s1_valid_q && (s1_op_q == OP_OBSERVE) && s1_in_range_q;
  assign cmem_we          = bmem_we;
  assign bmem_wdata       = sat_inc(bcnt_eff);
  assign cmem_wdata.sum   = ceff.sum + SUM_W'(s1_lat_q);
  assign cmem_wdata.total = sat_inc(ceff.total);

  // ---------------------------------------------------------------------------------------
  // query sequencer
  // ---------------------------------------------------------------------------------------
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [ACC_W-1:0] acc_new;
  logic [TGT_W-1:0] target_q, target_d;
  logic [CNT_W-1:0] res_value_q, res_value_d;
  logic [CNT_W-1:0] res_total_q, res_total_d;
  logic [PCT_W-1:0] pct_sat;
  logic             out_free;
  logic             out_load;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  assign pct_sat  = (s1_pct_q > PCT_MAX) ? PCT_MAX : s1_pct_q;
  // 100 * cumulative count is compared against total * p, which avoids the ceiling divide
  assign acc_new  = acc_q + ACC_W'(bcnt_eff) * ACC_W'(PCT_SCALE);
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    widx_d           = widx_q;
    acc_d            = acc_q;
    target_d         = target_q;
    res_value_d      = res_value_q;
    res_total_d      = res_total_q;
    out_load         = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = ceff.sum;
    div_req.divisor  = ceff.total;
    case (state_q)
      ST_IDLE: begin
        if (s1_query) begin
          res_total_d = s1_in_range_q ? ceff.total : '0;
          res_value_d = '0;
          state_d     = ST_EMIT;
          if (s1_in_range_q) begin
            case (s1_op_q)
              OP_PCT: begin
                if (ceff.total != '0) begin
                  target_d = TGT_W'(ceff.total) * TGT_W'(pct_sat);
                  widx_d   = '0;
                  acc_d    = '0;
                  state_d  = ST_WALK;
                end
              end
              OP_AVG: begin
                if (ceff.total != '0) begin
                  // quotient above 32 bits exactly when the upper sum half reaches the total
                  if (ceff.sum[SUM_W-1:CNT_W] >= ceff.total) begin
                    res_value_d = CNT_MAX;
                  end else begin
                    div_req.start = 1'b1;
                    state_d       = ST_DIV;
                  end
                end
              end
              OP_READ: begin
                res_value_d = s1_bidx_ok_q ? bcnt_eff : '0;
              end
              default: ;
            endcase
          end
        end
      end
      ST_WALK: begin
        if ((acc_new >= ACC_W'(target_q)) || (widx_q == LAST_BKT)) begin
          res_value_d = bucket_bound(widx_q);
          state_d     = ST_EMIT;
        end else begin
          acc_d  = acc_new;
          widx_d = widx_q + BKT_W'(1);
        end
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_value_d = div_rsp.quotient;
          state_d     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      widx_q  <= '0;
    end else begin
      state_q <= state_d;
      widx_q  <= widx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q       <= acc_d;
    target_q    <= target_d;
    res_value_q <= res_value_d;
    res_total_q <= res_total_d;
  end

  lhe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  // ---------------------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------------------
  logic             out_valid_q;
  logic [CNT_W-1:0] out_value_q;
  logic [CNT_W-1:0] out_total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_value_q <= res_value_q;
      out_total_q <= res_total_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign value_o        = out_value_q;
  assign sample_total_o = out_total_q;

  // ---------------------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------------------
  a_query_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (op_i != OP_OBSERVE)) |=> in_stall_o)
    else $error("query transfer did not hold off the next input transfer");

  a_no_writeback_in_query : assert property (@(posedge clk_i) disable iff (!rst_ni)
    bmem_we |-> (state_q == ST_IDLE))
    else $error("observe write-back while a query is in flight");

  a_walk_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (widx_q <= LAST_BKT))
    else $error("percentile walk ran past the last bucket");

  a_div_done_in_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == ST_DIV))
    else $error("divider finished outside of an average query");

endmodule

FILE: verif/lhe_scoreboard_pkg.sv
`timescale 1ns / 100ps
// lhe_scoreboard_pkg: histogram predictor and result scoreboard for the latency histogram engine
// depends on lhe_pkg for operation codes, bucket count and percentile limits
package lhe_scoreboard_pkg;
  import lhe_pkg::*;

  localparam int        HIST_CHANNELS   = DEF_NUM_CHANNELS;
  localparam bit [31:0] OVERFLOW_REPORT = 32'd10000000;
  localparam bit [31:0] BUCKET_LIMITS [NUM_BUCKETS-1] = '{
    32'd100, 32'd250, 32'd500, 32'd1000, 32'd2500, 32'd5000,
    32'd10000, 32'd25000, 32'd50000, 32'd100000, 32'd1000000
  };

  typedef struct {
    bit [31:0] value;
    bit [31:0] total;
  } query_result_t;

  class histogram_scoreboard;
    bit [31:0]     bucket_cnt [HIST_CHANNELS][NUM_BUCKETS];
    bit [31:0]     obs_total  [HIST_CHANNELS];
    bit [63:0]     lat_sum    [HIST_CHANNELS];
    query_result_t pending_q  [$];
    int            errors;

    // update the histograms for one accepted transfer and queue the answer a query earns
    function void note_item(op_e op, bit [2:0] ch, bit [31:0] lat, bit [6:0] pct,
                            bit [3:0] bidx);
      query_result_t res;
      int            slot;
      bit            found;
      bit [63:0]     pct_sat;
      bit [63:0]     target;
      bit [63:0]     cum;
      bit [63:0]     quot;
      res.value = '0;
      res.total = '0;
      if (ch >= HIST_CHANNELS) begin
        if (op != OP_OBSERVE) pending_q.push_back(res);
        return;
      end
      case (op)
        OP_OBSERVE: begin
          slot = NUM_BUCKETS - 1;
          for (int i = NUM_BUCKETS - 2; i >= 0; i--) begin
            if (lat <= BUCKET_LIMITS[i]) slot = i;
          end
          lat_sum[ch] += 64'(lat);
          if (obs_total[ch] != '1) obs_total[ch]++;
          if (bucket_cnt[ch][slot] != '1) bucket_cnt[ch][slot]++;
          return;
        end
        OP_PCT: begin
          if (obs_total[ch] != 0) begin
            pct_sat = (pct > PCT_MAX) ? 64'(PCT_MAX) : 64'(pct);
            target  = (64'(obs_total[ch]) * pct_sat + PCT_SCALE - 1) / PCT_SCALE;
            cum       = '0;
            found     = 1'b0;
            res.value = OVERFLOW_REPORT;
            for (int i = 0; i < NUM_BUCKETS; i++) begin
              cum += 64'(bucket_cnt[ch][i]);
              if (!found && cum >= target) begin
                found     = 1'b1;
                res.value = (i < NUM_BUCKETS - 1) ? BUCKET_LIMITS[i] : OVERFLOW_REPORT;
              end
            end
          end
        end
        OP_AVG: begin
          if (obs_total[ch] != 0) begin
            quot      = lat_sum[ch] / 64'(obs_total[ch]);
            res.value = (quot > 64'hFFFF_FFFF) ? '1 : quot[31:0];
          end
        end
        default: begin
          if (bidx < NUM_BUCKETS) res.value = bucket_cnt[ch][bidx];
        end
      endcase
      res.total = obs_total[ch];
      pending_q.push_back(res);
    endfunction

    function void check_result(logic [31:0] value, logic [31:0] total);
      query_result_t want;
      if (pending_q.size() == 0) begin
        $error("result with no query outstanding: value %0d sample_total %0d", value, total);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (value !== want.value) begin
        $error("value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (total !== want.total) begin
        $error("sample_total: expected %0d, got %0d", want.total, total);
        errors++;
      end
    endfunction

    function int pending();
      return pending_q.size();
    endfunction
  endclass

endpackage

FILE: verif/tb_latency_histogram_engine.sv
`timescale 1ns / 100ps
// tb_latency_histogram_engine: self-checking bench for latency_histogram_engine
// depends on lhe_pkg and lhe_scoreboard_pkg; drives directed then random transfers
module tb_latency_histogram_engine;
  import lhe_pkg::*;
  import lhe_scoreboard_pkg::*;

  localparam int ITEMS_PER_PHASE = 482;
  localparam int NUM_PHASES      = 4;
  localparam int SETTLE_CYCLES   = 64;
  // the watchdog limit covers the slowest legal run even with every query an average
  localparam int CYCLE_LIMIT     = 600000;
  // idle and stall rates per phase, in percent of cycles
  localparam int SEND_IDLE_PCT  [NUM_PHASES] = '{0, 46, 0, 18};
  localparam int RECV_STALL_PCT [NUM_PHASES] = '{0, 0, 46, 18};

  logic        clk          = 1'b0;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  op_e         op           = OP_OBSERVE;
  logic [2:0]  channel      = '0;
  logic [31:0] latency_us   = '0;
  logic [6:0]  percentile   = '0;
  logic [3:0]  bucket_index = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] value;
  logic [31:0] sample_total;

  int                  send_idle_pct  = 0;
  int                  recv_stall_pct = 0;
  int                  cycle_count    = 0;
  histogram_scoreboard sb;

  always #5 clk = ~clk;

  latency_histogram_engine i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op),
    .channel_i      (channel),
    .latency_us_i   (latency_us),
    .percentile_i   (percentile),
    .bucket_index_i (bucket_index),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .value_o        (value),
    .sample_total_o (sample_total)
  );

  // one input transfer: optional idle gap, then hold the payload until the engine takes it
  task automatic send_item(input op_e o, input logic [2:0] ch, input logic [31:0] lat,
                           input logic [6:0] pct, input logic [3:0] bidx);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    op           <= o;
    channel      <= ch;
    latency_us   <= lat;
    percentile   <= pct;
    bucket_index <= bidx;
    // values read right after the edge are the ones the edge sampled
    do begin
      @(posedge clk);
    end while (in_stall);
    sb.note_item(o, ch, lat, pct, bidx);
  endtask

  // mostly observes; latencies cluster on bucket edges, the rest spread wide
  task automatic send_random_item();
    int          pick;
    op_e         o;
    logic [31:0] lat;
    logic [6:0]  pct;
    logic [3:0]  bidx;
    pick = $urandom_range(99);
    if (pick < 65)      o = OP_OBSERVE;
    else if (pick < 77) o = OP_PCT;
    else if (pick < 87) o = OP_AVG;
    else                o = OP_READ;
    case ($urandom_range(3))
      0:       lat = BUCKET_LIMITS[$urandom_range(NUM_BUCKETS - 2)] + $urandom_range(2) - 1;
      1:       lat = $urandom;
      default: lat = $urandom_range(1200000);
    endcase
    // percentiles above 100 and bucket indexes past the last bucket now and then
    pct  = ($urandom_range(99) < 85) ? 7'($urandom_range(100)) : 7'($urandom_range(127));
    bidx = ($urandom_range(99) < 85) ? 4'($urandom_range(11)) : 4'($urandom_range(15));
    send_item(o, 3'($urandom_range(7)), lat, pct, bidx);
  endtask

  // stop sending and wait for every outstanding query to come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (sb.pending() != 0);
  endtask

  // result side: check each accepted result, then pick the next stall at random
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(value, sample_total);
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty histogram: percentile, average and bucket read give zero
    send_item(OP_PCT,  3'd3, $urandom, 7'd50, 4'($urandom));
    send_item(OP_AVG,  3'd3, $urandom, 7'($urandom), 4'($urandom));
    send_item(OP_READ, 3'd3, $urandom, 7'($urandom), 4'd0);
    // latencies on and just past bucket bounds, zero and full scale
    send_item(OP_OBSERVE, 3'd0, 32'd0,          7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd0, 32'd100,        7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd0, 32'd101,        7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd0, 32'd250,        7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd0, 32'd1000000,    7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd0, 32'd1000001,    7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd0, 32'hFFFF_FFFF,  7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd7, 32'hFFFF_FFFF,  7'($urandom), 4'($urandom));
    send_item(OP_OBSERVE, 3'd7, 32'd5000,       7'($urandom), 4'($urandom));
    // percentile zero, middle, full and saturated above 100, then averages on both channels
    send_item(OP_PCT, 3'd0, $urandom, 7'd0,   4'($urandom));
    send_item(OP_PCT, 3'd0, $urandom, 7'd50,  4'($urandom));
    send_item(OP_PCT, 3'd0, $urandom, 7'd100, 4'($urandom));
    send_item(OP_PCT, 3'd0, $urandom, 7'd127, 4'($urandom));
    send_item(OP_PCT, 3'd7, $urandom, 7'd1,   4'($urandom));
    send_item(OP_AVG, 3'd0, $urandom, 7'($urandom), 4'($urandom));
    send_item(OP_AVG, 3'd7, $urandom, 7'($urandom), 4'($urandom));
    // first, overflow and out-of-range buckets
    send_item(OP_READ, 3'd0, $urandom, 7'($urandom), 4'd0);
    send_item(OP_READ, 3'd0, $urandom, 7'($urandom), 4'd11);
    send_item(OP_READ, 3'd0, $urandom, 7'($urandom), 4'd15);
    send_item(OP_READ, 3'd7, $urandom, 7'($urandom), 4'd12);
    drain_results();

    // random phases, each ending with a full drain of outstanding queries
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      send_idle_pct  = SEND_IDLE_PCT[ph];
      recv_stall_pct = RECV_STALL_PCT[ph];
      repeat (ITEMS_PER_PHASE) send_random_item();
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lhe_pkg.sv
rtl/lhe_div.sv
rtl/latency_histogram_engine.sv
verif/lhe_scoreboard_pkg.sv
verif/tb_latency_histogram_engine.sv
